/* src/ttb_pkg.sv */
// ----------------------------------------------------------------------------
// ttb_pkg: shared widths, types and arithmetic steps
// Constants, payload types and the square-root and division step functions
// used by the tangent basis pipeline.
// ----------------------------------------------------------------------------
package ttb_pkg;

  // Width of one packed coordinate component.
  localparam int COORD_WIDTH = 16;
  // Edge and UV deltas carry one extra bit.
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int DIR_W       = PROD_W + 1;
  localparam int MAG_W       = DIR_W;
  localparam int POS_W       = $clog2(MAG_W);
  // Normalized magnitudes keep their top bit at this position.
  localparam int NRM_TOP     = 29;
  localparam int NRM_W       = NRM_TOP + 1;
  localparam int SH_W        = MAG_W + NRM_W;
  localparam int SQ_W        = 2 * NRM_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int ROOT_W      = NRM_W + 1;
  localparam int OUT_FRAC    = COORD_WIDTH - 2;
  localparam int QUO_W       = OUT_FRAC + 1;
  localparam int NUM_W       = NRM_W + OUT_FRAC + 1;
  localparam int SQRT_STAGES = (ROOT_W + 1) / 2;
  localparam int DIV_STAGES  = (QUO_W + 1) / 2;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DIR_W-1:0]  dir_t;
  typedef logic [2:0][MAG_W-1:0]    mag_vec_t;
  typedef logic [2:0][NRM_W-1:0]    nrm_vec_t;
  typedef logic [2:0][NUM_W-1:0]    num_vec_t;
  typedef logic [2:0][QUO_W-1:0]    quo_vec_t;

  // Control that travels alongside each item in the normalizer.
  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] neg;
  } side_t;

  // Sign-extend one packed component to delta width.
  function automatic diff_t sx(input logic [COORD_WIDTH-1:0] c);
    return diff_t'(signed'(c));
  endfunction

  // One digit of the square root: decides root bit i.
  function automatic logic [SUM_W+ROOT_W-1:0] sqrt_step(input logic [SUM_W-1:0]  rem,
                                                        input logic [ROOT_W-1:0] root,
                                                        input int                i);
    logic [SUM_W-1:0] trial;
    trial = (SUM_W'(root) << (i + 1)) | (SUM_W'(1) << (2 * i));
    if (rem >= trial) begin
      return {rem - trial, root | (ROOT_W'(1) << i)};
    end
    return {rem, root};
  endfunction

  // One restoring division step: decides quotient bit j.
  function automatic logic [NUM_W+QUO_W-1:0] div_step(input logic [NUM_W-1:0]  rem,
                                                      input logic [ROOT_W-1:0] dvs,
                                                      input logic [QUO_W-1:0]  quo,
                                                      input int                j);
    logic [NUM_W-1:0] trial;
    trial = NUM_W'(dvs) << j;
    if (rem >= trial) begin
      return {rem - trial, quo | (QUO_W'(1) << j)};
    end
    return {rem, quo};
  endfunction

endpackage

/* src/ttb_front.sv */
// ----------------------------------------------------------------------------
// ttb_front: edge, UV delta and direction stages
// Four register stages form the deltas, the products, the raw directions and
// the determinant, then orient both directions by the determinant sign.
// ----------------------------------------------------------------------------
module ttb_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [3*ttb_pkg::COORD_WIDTH-1:0]   in_p0,
  input  logic [3*ttb_pkg::COORD_WIDTH-1:0]   in_p1,
  input  logic [3*ttb_pkg::COORD_WIDTH-1:0]   in_p2,
  input  logic [2*ttb_pkg::COORD_WIDTH-1:0]   in_t0,
  input  logic [2*ttb_pkg::COORD_WIDTH-1:0]   in_t1,
  input  logic [2*ttb_pkg::COORD_WIDTH-1:0]   in_t2,
  output logic                                out_valid,
  output ttb_pkg::dir_t                       out_tan [3],
  output ttb_pkg::dir_t                       out_bit [3]
);

  localparam int W = ttb_pkg::COORD_WIDTH;

  logic [3:0]      v_r;
  ttb_pkg::diff_t  e1_r [3];
  ttb_pkg::diff_t  e2_r [3];
  ttb_pkg::diff_t  d1u_r, d1v_r, d2u_r, d2v_r;
  ttb_pkg::prod_t  pt1_r [3];
  ttb_pkg::prod_t  pt2_r [3];
  ttb_pkg::prod_t  pb1_r [3];
  ttb_pkg::prod_t  pb2_r [3];
  ttb_pkg::prod_t  pd1_r, pd2_r;
  ttb_pkg::dir_t   tan_r [3];
  ttb_pkg::dir_t   bit_r [3];
  ttb_pkg::dir_t   det_r;
  ttb_pkg::dir_t   tan_o_r [3];
  ttb_pkg::dir_t   bit_o_r [3];

  // Valid bits follow the items through the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  // Stage 1: edges and UV deltas.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e1_r[i] <= ttb_pkg::sx(in_p1[(2-i)*W +: W]) - ttb_pkg::sx(in_p0[(2-i)*W +: W]);
      e2_r[i] <= ttb_pkg::sx(in_p2[(2-i)*W +: W]) - ttb_pkg::sx(in_p0[(2-i)*W +: W]);
    end
    d1u_r <= ttb_pkg::sx(in_t1[W +: W]) - ttb_pkg::sx(in_t0[W +: W]);
    d1v_r <= ttb_pkg::sx(in_t1[0 +: W]) - ttb_pkg::sx(in_t0[0 +: W]);
    d2u_r <= ttb_pkg::sx(in_t2[W +: W]) - ttb_pkg::sx(in_t0[W +: W]);
    d2v_r <= ttb_pkg::sx(in_t2[0 +: W]) - ttb_pkg::sx(in_t0[0 +: W]);
  end

  // Stage 2: all products, one multiplier each.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pt1_r[i] <= ttb_pkg::prod_t'(d2v_r) * ttb_pkg::prod_t'(e1_r[i]);
      pt2_r[i] <= ttb_pkg::prod_t'(d1v_r) * ttb_pkg::prod_t'(e2_r[i]);
      pb1_r[i] <= ttb_pkg::prod_t'(d1u_r) * ttb_pkg::prod_t'(e2_r[i]);
      pb2_r[i] <= ttb_pkg::prod_t'(d2u_r) * ttb_pkg::prod_t'(e1_r[i]);
    end
    pd1_r <= ttb_pkg::prod_t'(d1u_r) * ttb_pkg::prod_t'(d2v_r);
    pd2_r <= ttb_pkg::prod_t'(d2u_r) * ttb_pkg::prod_t'(d1v_r);
  end

  // Stage 3: raw directions and determinant.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      tan_r[i] <= ttb_pkg::dir_t'(pt1_r[i]) - ttb_pkg::dir_t'(pt2_r[i]);
      bit_r[i] <= ttb_pkg::dir_t'(pb1_r[i]) - ttb_pkg::dir_t'(pb2_r[i]);
    end
    det_r <= ttb_pkg::dir_t'(pd1_r) - ttb_pkg::dir_t'(pd2_r);
  end

  // Stage 4: flip on a negative determinant; a zero determinant kills the tangent.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (det_r == '0) begin
        tan_o_r[i] <= '0;
      end else if (det_r[ttb_pkg::DIR_W-1]) begin
        tan_o_r[i] <= -tan_r[i];
      end else begin
        tan_o_r[i] <= tan_r[i];
      end
      bit_o_r[i] <= det_r[ttb_pkg::DIR_W-1] ? -bit_r[i] : bit_r[i];
    end
  end

  assign out_valid = v_r[3];
  assign out_tan   = tan_o_r;
  assign out_bit   = bit_o_r;

endmodule

/* src/ttb_norm.sv */
// ----------------------------------------------------------------------------
// ttb_norm: vector normalizer
// Scales a direction to a fixed magnitude window, sums the squares, takes a
// pipelined integer square root and divides each component by the length.
// ----------------------------------------------------------------------------
module ttb_norm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  ttb_pkg::dir_t                     in_vec [3],
  output logic                              out_valid,
  output logic [3*ttb_pkg::COORD_WIDTH-1:0] out_vec,
  output logic                              out_invalid
);

  localparam int W   = ttb_pkg::COORD_WIDTH;
  localparam int SQS = ttb_pkg::SQRT_STAGES;
  localparam int DVS = ttb_pkg::DIV_STAGES;

  ttb_pkg::side_t     sd1_r, sd2_r, sd3_r, sd4_r, sd5_r, sd6_r, sdp_r, sdo_r;
  ttb_pkg::mag_vec_t  mg1_r, mg2_r, mg3_r;
  logic [ttb_pkg::MAG_W-1:0]  m_r;
  logic [ttb_pkg::POS_W-1:0]  pos_nxt, pos_r;
  ttb_pkg::nrm_vec_t  nm4_r, nm5_r;
  logic [2:0][ttb_pkg::SQ_W-1:0] sq_r;
  logic [ttb_pkg::SUM_W-1:0]  sum_r;
  ttb_pkg::num_vec_t  num_r;
  logic [ttb_pkg::ROOT_W-1:0] len_r;
  logic [3*W-1:0]     vec_r;

  // Stage 1: signs and magnitudes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd1_r <= '0;
    end else begin
      sd1_r.valid <= in_valid;
      sd1_r.zero  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sd1_r.neg[i] <= in_vec[i][ttb_pkg::DIR_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mg1_r[i] <= in_vec[i][ttb_pkg::DIR_W-1] ? ttb_pkg::MAG_W'(-in_vec[i])
                                              : ttb_pkg::MAG_W'(in_vec[i]);
    end
  end

  // Stage 2: largest magnitude.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd2_r <= '0;
    end else begin
      sd2_r <= sd1_r;
    end
  end

  always_ff @(posedge clk) begin
    mg2_r <= mg1_r;
    if (mg1_r[0] >= mg1_r[1] && mg1_r[0] >= mg1_r[2]) begin
      m_r <= mg1_r[0];
    end else if (mg1_r[1] >= mg1_r[2]) begin
      m_r <= mg1_r[1];
    end else begin
      m_r <= mg1_r[2];
    end
  end

  // Stage 3: position of the leading one.
  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < ttb_pkg::MAG_W; i++) begin
      if (m_r[i]) begin
        pos_nxt = ttb_pkg::POS_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd3_r <= '0;
    end else begin
      sd3_r <= '{valid: sd2_r.valid, zero: (m_r == '0), neg: sd2_r.neg};
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    mg3_r <= mg2_r;
  end

  // Stage 4: shift so the largest magnitude lands on the window top.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd4_r <= '0;
    end else begin
      sd4_r <= sd3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (pos_r >= ttb_pkg::POS_W'(ttb_pkg::NRM_TOP)) begin
        nm4_r[i] <= ttb_pkg::NRM_W'(ttb_pkg::SH_W'(mg3_r[i])
                    >> (pos_r - ttb_pkg::POS_W'(ttb_pkg::NRM_TOP)));
      end else begin
        nm4_r[i] <= ttb_pkg::NRM_W'(ttb_pkg::SH_W'(mg3_r[i])
                    << (ttb_pkg::POS_W'(ttb_pkg::NRM_TOP) - pos_r));
      end
    end
  end

  // Stage 5: squares.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd5_r <= '0;
    end else begin
      sd5_r <= sd4_r;
    end
  end

  always_ff @(posedge clk) begin
    nm5_r <= nm4_r;
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= ttb_pkg::SQ_W'(nm4_r[i]) * ttb_pkg::SQ_W'(nm4_r[i]);
    end
  end

  // Stage 6: sum of squares.
  ttb_pkg::nrm_vec_t nm6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd6_r <= '0;
    end else begin
      sd6_r <= sd5_r;
    end
  end

  always_ff @(posedge clk) begin
    nm6_r <= nm5_r;
    sum_r <= ttb_pkg::SUM_W'(sq_r[0]) + ttb_pkg::SUM_W'(sq_r[1]) + ttb_pkg::SUM_W'(sq_r[2]);
  end

  // Square root pipeline: two root bits per stage, one in the last stage.
  logic [ttb_pkg::SUM_W-1:0]  sr_rem  [SQS+1];
  logic [ttb_pkg::ROOT_W-1:0] sr_root [SQS+1];
  ttb_pkg::side_t             sr_sd   [SQS+1];
  ttb_pkg::nrm_vec_t          sr_mg   [SQS+1];

  assign sr_rem[0]  = sum_r;
  assign sr_root[0] = '0;
  assign sr_sd[0]   = sd6_r;
  assign sr_mg[0]   = nm6_r;

  for (genvar k = 0; k < SQS; k++) begin : g_sqrt
    localparam int BHI = ttb_pkg::ROOT_W - 1 - 2 * k;
    localparam int BLO = BHI - 1;
    logic [ttb_pkg::SUM_W+ttb_pkg::ROOT_W-1:0] s_hi, s_lo;
    logic [ttb_pkg::SUM_W-1:0]  rem_r;
    logic [ttb_pkg::ROOT_W-1:0] root_r;
    ttb_pkg::side_t             sd_r;
    ttb_pkg::nrm_vec_t          mg_r;

    assign s_hi = ttb_pkg::sqrt_step(sr_rem[k], sr_root[k], BHI);
    if (BLO >= 0) begin : g_lo
      assign s_lo = ttb_pkg::sqrt_step(s_hi[ttb_pkg::ROOT_W +: ttb_pkg::SUM_W],
                                       s_hi[ttb_pkg::ROOT_W-1:0], BLO);
    end else begin : g_last
      assign s_lo = s_hi;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r <= '0;
      end else begin
        sd_r <= sr_sd[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r  <= s_lo[ttb_pkg::ROOT_W +: ttb_pkg::SUM_W];
      root_r <= s_lo[ttb_pkg::ROOT_W-1:0];
      mg_r   <= sr_mg[k];
    end

    assign sr_rem[k+1]  = rem_r;
    assign sr_root[k+1] = root_r;
    assign sr_sd[k+1]   = sd_r;
    assign sr_mg[k+1]   = mg_r;
  end

  // Dividend setup: scaled magnitude plus half the length for rounding.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sdp_r <= '0;
    end else begin
      sdp_r <= sr_sd[SQS];
    end
  end

  always_ff @(posedge clk) begin
    len_r <= sr_root[SQS];
    for (int i = 0; i < 3; i++) begin
      num_r[i] <= (ttb_pkg::NUM_W'(sr_mg[SQS][i]) << ttb_pkg::OUT_FRAC)
                  + ttb_pkg::NUM_W'(sr_root[SQS] >> 1);
    end
  end

  // Division pipeline: two quotient bits per stage, one in the last stage, three components in parallel.
  ttb_pkg::num_vec_t          dv_rem [DVS+1];
  ttb_pkg::quo_vec_t          dv_quo [DVS+1];
  logic [ttb_pkg::ROOT_W-1:0] dv_len [DVS+1];
  ttb_pkg::side_t             dv_sd  [DVS+1];

  assign dv_rem[0] = num_r;
  assign dv_quo[0] = '0;
  assign dv_len[0] = len_r;
  assign dv_sd[0]  = sdp_r;

  for (genvar k = 0; k < DVS; k++) begin : g_div
    localparam int BHI = ttb_pkg::QUO_W - 1 - 2 * k;
    localparam int BLO = BHI - 1;
    ttb_pkg::num_vec_t          rem_r;
    ttb_pkg::quo_vec_t          quo_r;
    logic [ttb_pkg::ROOT_W-1:0] len_r;
    ttb_pkg::side_t             sd_r;

    for (genvar c = 0; c < 3; c++) begin : g_comp
      logic [ttb_pkg::NUM_W+ttb_pkg::QUO_W-1:0] s_hi, s_lo;
      assign s_hi = ttb_pkg::div_step(dv_rem[k][c], dv_len[k], dv_quo[k][c], BHI);
      if (BLO >= 0) begin : g_lo
        assign s_lo = ttb_pkg::div_step(s_hi[ttb_pkg::QUO_W +: ttb_pkg::NUM_W], dv_len[k],
                                        s_hi[ttb_pkg::QUO_W-1:0], BLO);
      end else begin : g_last
        assign s_lo = s_hi;
      end

      always_ff @(posedge clk) begin
        rem_r[c] <= s_lo[ttb_pkg::QUO_W +: ttb_pkg::NUM_W];
        quo_r[c] <= s_lo[ttb_pkg::QUO_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r <= '0;
      end else begin
        sd_r <= dv_sd[k];
      end
    end

    always_ff @(posedge clk) begin
      len_r <= dv_len[k];
    end

    assign dv_rem[k+1] = rem_r;
    assign dv_quo[k+1] = quo_r;
    assign dv_len[k+1] = len_r;
    assign dv_sd[k+1]  = sd_r;
  end

  // Output stage: restore signs, pack x in the top bits, zero an empty vector.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sdo_r <= '0;
    end else begin
      sdo_r <= dv_sd[DVS];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (dv_sd[DVS].zero) begin
        vec_r[(2-c)*W +: W] <= '0;
      end else if (dv_sd[DVS].neg[c]) begin
        vec_r[(2-c)*W +: W] <= -W'(dv_quo[DVS][c]);
      end else begin
        vec_r[(2-c)*W +: W] <= W'(dv_quo[DVS][c]);
      end
    end
  end

  assign out_valid   = sdo_r.valid;
  assign out_invalid = sdo_r.zero;
  assign out_vec     = vec_r;

endmodule

/* src/triangle_tangent_basis.sv */
// ----------------------------------------------------------------------------
// triangle_tangent_basis: per-triangle tangent and bitangent
// Computes unit tangent and bitangent vectors of one triangle per cycle.
// ----------------------------------------------------------------------------
// A triangle is taken on every cycle that start is high; busy is always low.
// Its result appears for one cycle with out_strobe high, and the results
// come out in the order the triangles went in. The pipeline is fixed: four
// stages for deltas, products and orientation, six for scaling and the sum of
// squares, sixteen square-root stages of two length bits each, one in the last,
// one dividend stage, eight divider stages of two quotient bits each, one in
// the last, and an output register. Results cannot be held off, so the
// receiver must take each one in the cycle it is shown.
module triangle_tangent_basis (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [3*ttb_pkg::COORD_WIDTH-1:0]   in_corner0_position,
  input  logic [3*ttb_pkg::COORD_WIDTH-1:0]   in_corner1_position,
  input  logic [3*ttb_pkg::COORD_WIDTH-1:0]   in_corner2_position,
  input  logic [2*ttb_pkg::COORD_WIDTH-1:0]   in_corner0_uv,
  input  logic [2*ttb_pkg::COORD_WIDTH-1:0]   in_corner1_uv,
  input  logic [2*ttb_pkg::COORD_WIDTH-1:0]   in_corner2_uv,
  output logic                                out_strobe,
  output logic [3*ttb_pkg::COORD_WIDTH-1:0]   out_tangent_vector,
  output logic [3*ttb_pkg::COORD_WIDTH-1:0]   out_bitangent_vector,
  output logic                                out_tangent_invalid,
  output logic                                out_bitangent_invalid
);

  logic          fr_valid;
  ttb_pkg::dir_t fr_tan [3];
  ttb_pkg::dir_t fr_bit [3];
  logic          bit_valid;

  // The pipeline never stalls, so an item is always taken.
  assign busy = 1'b0;

  // Deltas, products and orientation.
  ttb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_p0     (in_corner0_position),
    .in_p1     (in_corner1_position),
    .in_p2     (in_corner2_position),
    .in_t0     (in_corner0_uv),
    .in_t1     (in_corner1_uv),
    .in_t2     (in_corner2_uv),
    .out_valid (fr_valid),
    .out_tan   (fr_tan),
    .out_bit   (fr_bit)
  );

  // Tangent normalizer.
  ttb_norm u_norm_tan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (fr_valid),
    .in_vec      (fr_tan),
    .out_valid   (out_strobe),
    .out_vec     (out_tangent_vector),
    .out_invalid (out_tangent_invalid)
  );

  // Bitangent normalizer.
  ttb_norm u_norm_bit (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (fr_valid),
    .in_vec      (fr_bit),
    .out_valid   (bit_valid),
    .out_vec     (out_bitangent_vector),
    .out_invalid (out_bitangent_invalid)
  );

  // Both normalizers must deliver the same item in the same cycle.
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe == bit_valid)
    else $error("tangent and bitangent results are out of step");

  // A flagged tangent carries a zero vector.
  a_tan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_tangent_invalid |-> out_tangent_vector == '0)
    else $error("invalid tangent is not zero");

  // A flagged bitangent carries a zero vector.
  a_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_bitangent_invalid |-> out_bitangent_vector == '0)
    else $error("invalid bitangent is not zero");

  // A valid bitangent can never come out as all zeros.
  a_bit_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_bitangent_invalid |-> out_bitangent_vector != '0)
    else $error("valid bitangent is zero");

endmodule

/* test/tb_triangle_tangent_basis.sv */
// ----------------------------------------------------------------------------
// tb_triangle_tangent_basis: self-checking bench for the tangent basis block
// Drives directed and random triangles in bursts, predicts each tangent and
// bitangent with an integer model, and compares every strobed output item.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_basis;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W   = ttb_pkg::COORD_WIDTH;
  localparam int PW  = 3 * W;
  localparam int UW  = 2 * W;
  localparam int LAT = 36;

  typedef struct {
    logic [PW-1:0] p0, p1, p2;
    logic [UW-1:0] t0, t1, t2;
  } tri_t;

  typedef struct {
    logic [PW-1:0] tangent, bitangent;
    logic          tan_bad, bit_bad;
  } basis_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [PW-1:0] in_corner0_position = '0, in_corner1_position = '0;
  logic [PW-1:0] in_corner2_position = '0;
  logic [UW-1:0] in_corner0_uv = '0, in_corner1_uv = '0, in_corner2_uv = '0;
  logic out_strobe, out_tangent_invalid, out_bitangent_invalid;
  logic [PW-1:0] out_tangent_vector, out_bitangent_vector;

  tri_t   pending_tris[$];
  basis_t expected_basis[$];
  int     mismatches = 0;
  bit     stimulus_done = 0;

  triangle_tangent_basis DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_corner0_position(in_corner0_position),
    .in_corner1_position(in_corner1_position),
    .in_corner2_position(in_corner2_position),
    .in_corner0_uv(in_corner0_uv), .in_corner1_uv(in_corner1_uv),
    .in_corner2_uv(in_corner2_uv),
    .out_strobe(out_strobe), .out_tangent_vector(out_tangent_vector),
    .out_bitangent_vector(out_bitangent_vector),
    .out_tangent_invalid(out_tangent_invalid),
    .out_bitangent_invalid(out_bitangent_invalid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Signed component in packed slot s (slot 0 is the low component).
  function automatic longint comp(logic [PW-1:0] w, int s);
    logic signed [W-1:0] c;
    c = w[s*W +: W];
    return longint'(c);
  endfunction

  // Scale a direction to unit length in Q1.(W-2); zero direction gives 0.
  function automatic logic [PW+1-1:0] unit_vec(longint a[3]);
    longint unsigned mag[3], m, s, len, q;
    logic [PW-1:0] word;
    m = 0;
    word = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (a[i] < 0) ? longint'(-a[i]) : a[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return {1'b0, word};
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    s = 0;
    for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
    // Integer square root, bit by bit.
    len = 0;
    for (int b = 31; b >= 0; b--)
      if ((len + (64'd1 << b)) * (len + (64'd1 << b)) <= s) len += 64'd1 << b;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << (W - 2)) + (len >> 1)) / len;
      if (a[i] < 0) q = -q;
      word[(2 - i)*W +: W] = q[W-1:0];
    end
    return {1'b1, word};
  endfunction

  function automatic basis_t predict_basis(tri_t t);
    basis_t r;
    longint e1[3], e2[3], tn[3], bt[3];
    longint d1u, d1v, d2u, d2v, det;
    logic [PW:0] tu, bu;
    for (int i = 0; i < 3; i++) begin
      e1[i] = comp(t.p1, 2 - i) - comp(t.p0, 2 - i);
      e2[i] = comp(t.p2, 2 - i) - comp(t.p0, 2 - i);
    end
    d1u = comp(PW'(t.t1), 1) - comp(PW'(t.t0), 1);
    d1v = comp(PW'(t.t1), 0) - comp(PW'(t.t0), 0);
    d2u = comp(PW'(t.t2), 1) - comp(PW'(t.t0), 1);
    d2v = comp(PW'(t.t2), 0) - comp(PW'(t.t0), 0);
    det = d1u * d2v - d2u * d1v;
    for (int i = 0; i < 3; i++) begin
      tn[i] = d2v * e1[i] - d1v * e2[i];
      bt[i] = d1u * e2[i] - d2u * e1[i];
      if (det < 0) begin
        tn[i] = -tn[i];
        bt[i] = -bt[i];
      end
    end
    tu = unit_vec(tn);
    bu = unit_vec(bt);
    r.tangent   = (det == 0) ? '0 : tu[PW-1:0];
    r.tan_bad   = (det == 0) || !tu[PW];
    r.bitangent = bu[PW-1:0];
    r.bit_bad   = !bu[PW];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [PW-1:0] got, logic [PW-1:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [PW-1:0] rand_pos();
    return PW'({$urandom(), $urandom()});
  endfunction

  // Small components keep most triangles well conditioned.
  function automatic logic [W-1:0] rand_comp();
    case ($urandom_range(3))
      0: return W'($urandom());
      1: return W'($signed($urandom_range(64)) - 32);
      2: return W'({$urandom_range(1) ? 1'b1 : 1'b0, W'(0)} >> 1);
      default: return W'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    t.p0 = {rand_comp(), rand_comp(), rand_comp()};
    t.p1 = {rand_comp(), rand_comp(), rand_comp()};
    t.p2 = {rand_comp(), rand_comp(), rand_comp()};
    t.t0 = {rand_comp(), rand_comp()};
    t.t1 = {rand_comp(), rand_comp()};
    t.t2 = {rand_comp(), rand_comp()};
    if ($urandom_range(9) == 0) t.p0 = rand_pos();
    // Sometimes repeat a corner to force degenerate cases.
    if ($urandom_range(15) == 0) t.t2 = t.t1;
    if ($urandom_range(15) == 0) t.p2 = t.p0;
    return t;
  endfunction

  // Stimulus: directed corners first, then random triangles.
  initial begin
    tri_t t;
    logic [W-1:0] mx, mn;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    // Right triangle with a standard UV layout.
    t = '{p0: '0, p1: {W'(256), W'(0), W'(0)}, p2: {W'(0), W'(256), W'(0)},
          t0: '0, t1: {W'(4096), W'(0)}, t2: {W'(0), W'(4096)}};
    pending_tris = {pending_tris, t};
    // Mirrored UVs give a negative determinant.
    t.t1 = {W'(0), W'(4096)};
    t.t2 = {W'(4096), W'(0)};
    pending_tris = {pending_tris, t};
    // Zero determinant: all UVs equal.
    t.t0 = {W'(5), W'(7)}; t.t1 = t.t0; t.t2 = t.t0;
    pending_tris = {pending_tris, t};
    // Collinear UVs, nonzero edges.
    t.t1 = {W'(100), W'(100)}; t.t2 = {W'(200), W'(200)}; t.t0 = '0;
    pending_tris = {pending_tris, t};
    // Zero-length directions: all positions equal.
    t = '{p0: {mx, mn, mx}, p1: {mx, mn, mx}, p2: {mx, mn, mx},
          t0: '0, t1: {W'(4096), W'(0)}, t2: {W'(0), W'(4096)}};
    pending_tris = {pending_tris, t};
    // Extremes, with deltas at their full range.
    t = '{p0: {mn, mn, mn}, p1: {mx, mx, mx}, p2: {mx, mn, mx},
          t0: {mn, mn}, t1: {mx, mn}, t2: {mn, mx}};
    pending_tris = {pending_tris, t};
    t = '{p0: {mx, mx, mx}, p1: {mn, mn, mn}, p2: {mn, mx, mn},
          t0: {mx, mx}, t1: {mn, mx}, t2: {mx, mn}};
    pending_tris = {pending_tris, t};
    t = '{p0: '1, p1: '0, p2: {W'(1), W'(0), W'(0)},
          t0: '1, t1: '0, t2: {W'(0), W'(1)}};
    pending_tris = {pending_tris, t};
    t = '{p0: '0, p1: '1, p2: {PW{1'b1}} >> 1, t0: '0, t1: '1, t2: {UW{1'b1}} >> 3};
    pending_tris = {pending_tris, t};
    for (int i = 0; i < 1500; i++) pending_tris = {pending_tris, rand_tri()};
    stimulus_done = 1;
  end

  // Driver: bursts of back-to-back items separated by random gaps.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        tri_t sent;
        sent = '{p0: in_corner0_position, p1: in_corner1_position,
                 p2: in_corner2_position, t0: in_corner0_uv,
                 t1: in_corner1_uv, t2: in_corner2_uv};
        expected_basis = {expected_basis, predict_basis(sent)};
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_tris.size() > 0) begin
        tri_t t;
        t = pending_tris.pop_front();
        in_corner0_position <= t.p0;
        in_corner1_position <= t.p1;
        in_corner2_position <= t.p2;
        in_corner0_uv <= t.t0;
        in_corner1_uv <= t.t1;
        in_corner2_uv <= t.t2;
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(40);
          gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed item is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      basis_t want;
      if (expected_basis.size() == 0) begin
        report_mismatch("unexpected item", out_tangent_vector, '0);
      end else begin
        want = expected_basis.pop_front();
        if (out_tangent_vector !== want.tangent)
          report_mismatch("tangent", out_tangent_vector, want.tangent);
        if (out_bitangent_vector !== want.bitangent)
          report_mismatch("bitangent", out_bitangent_vector, want.bitangent);
        if (out_tangent_invalid !== want.tan_bad)
          report_mismatch("tangent_invalid", PW'(out_tangent_invalid), PW'(want.tan_bad));
        if (out_bitangent_invalid !== want.bit_bad)
          report_mismatch("bitangent_invalid", PW'(out_bitangent_invalid),
                          PW'(want.bit_bad));
      end
    end
  end

  // Reset, then wait for the stimulus to drain and the pipeline to empty.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && pending_tris.size() == 0 && !start);
    while (expected_basis.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (mismatches == 0 && expected_basis.size() == 0)
      $display("triangle_tangent_basis: match");
    else
      $display("triangle_tangent_basis: mismatch");
    $finish;
  end

  initial begin
    #200000;
    $display("triangle_tangent_basis: mismatch");
    $finish;
  end

endmodule

/* sim.f */
src/ttb_pkg.sv
src/ttb_front.sv
src/ttb_norm.sv
src/triangle_tangent_basis.sv
test/tb_triangle_tangent_basis.sv
